// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the priority task table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a condition at every clock edge out of reset.
`define CHECK_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent.
`define CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CHECK_ALWAYS(label, cond, msg)
`define CHECK_SAME(label, ante, cons, msg)
`define CHECK_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- sv/pstt_pkg.sv -----
// Types, codes and constants of the priority task table.
`timescale 1ns / 1ps
`default_nettype none

package pstt_pkg;

    localparam int PSTT_CAPACITY = 16;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_CHANGE = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_LIST   = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        OUT_DONE      = 3'd0,
        OUT_NOT_FOUND = 3'd1,
        OUT_FULL      = 3'd2,
        OUT_ENTRY     = 3'd3,
        OUT_EMPTY     = 3'd4
    } outcome_t;

    localparam logic [1:0] STATUS_NEW       = 2'd0;
    localparam logic [1:0] STATUS_COMPLETED = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_LIST_RD,
        ST_LIST_OUT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] priority_req;
        logic [15:0]        name_tag;
        logic [1:0]         new_status;
    } req_t;

    typedef struct packed {
        logic [2:0]         outcome;
        logic signed [15:0] entry_priority;
        logic [15:0]        entry_tag;
        logic [1:0]         entry_status;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        tag;
        logic signed [15:0] prio;
    } entry_t;

    localparam int PSTT_ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_t;

endpackage

`default_nettype wire

// ----- sv/priority_sorted_task_table.sv -----
// Top level of the priority task table: sequencer, entry RAM and comparator.
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | pstt_pkg::req_t
//  rsp     | out | rsp_valid/rsp_stall | pstt_pkg::rsp_t
//
// One request at a time; req_stall stays high until its last result is registered.
// Insert reads and writes each entry moved up, then writes the new one; change/delete
// read and check each entry probed, and delete then reads and writes each entry moved
// down; list reads and emits each entry. All walk the single RAM port of the sequencer.
// Reset empties the table at once through the entry count; no clearing pass.
// A stalled rsp holds the sequencer only in the result states.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module priority_sorted_task_table #(
    parameter int CAPACITY = pstt_pkg::PSTT_CAPACITY
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire pstt_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output pstt_pkg::rsp_t       rsp
);

    import pstt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    req_t           req_reg, req_next;
    logic [2:0]     outcome_reg, outcome_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rsp_t           rsp_reg, rsp_next;

    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    entry_t         ram_wdata;
    logic [IW-1:0]  ram_raddr;
    entry_t         ram_rdata;
    cmp_t           cmp_res;

    logic           accept;
    logic           rsp_free;
    logic           shift_up;
    logic [1:0]     sat_status;
    entry_t         new_entry;

    pstt_ram #(
        .WIDTH (PSTT_ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pstt_cmp u_cmp (
        .stored (ram_rdata.prio),
        .key    (req_reg.priority_req),
        .res    (cmp_res)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign sat_status = (req_reg.new_status > STATUS_COMPLETED) ? STATUS_COMPLETED
                                                                : req_reg.new_status;
    assign new_entry  = '{status: STATUS_NEW, tag: req_reg.name_tag,
                          prio: req_reg.priority_req};
    assign shift_up   = (idx_reg == CW'(1)) ? cmp_res.gt : (cmp_res.gt || cmp_res.eq);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        outcome_next   = outcome_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[IW-1:0];
        ram_wdata      = new_entry;
        ram_raddr      = idx_reg[IW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    idx_next = '0;
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                outcome_next = OUT_FULL;
                                state_next   = ST_EMIT;
                            end
                            else if (count_reg == '0)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = '0;
                                ram_wdata    = '{status: STATUS_NEW, tag: req.name_tag,
                                                 prio: req.priority_req};
                                count_next   = CW'(1);
                                outcome_next = OUT_DONE;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        REQ_CHANGE, REQ_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                outcome_next = OUT_NOT_FOUND;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_FIND_RD;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                outcome_next = OUT_EMPTY;
                                state_next   = ST_EMIT;
                            end
                            else
                            begin
                                state_next = ST_LIST_RD;
                            end
                        end
                    endcase
                end
            end
            ST_INS_RD:
            begin
                ram_raddr  = IW'(idx_reg - CW'(1));
                state_next = ST_INS_WR;
            end
            ST_INS_WR:
            begin
                if (shift_up)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_reg - CW'(1);
                    state_next = (idx_reg == CW'(1)) ? ST_INS_PUT : ST_INS_RD;
                end
                else
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT:
            begin
                ram_we       = 1'b1;
                count_next   = count_reg + CW'(1);
                outcome_next = OUT_DONE;
                state_next   = ST_EMIT;
            end
            ST_FIND_RD:
            begin
                state_next = ST_FIND_CHK;
            end
            ST_FIND_CHK:
            begin
                if (cmp_res.eq)
                begin
                    outcome_next = OUT_DONE;
                    if (req_reg.req_type == REQ_CHANGE)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = '{status: sat_status, tag: ram_rdata.tag,
                                       prio: ram_rdata.prio};
                        state_next = ST_EMIT;
                    end
                    else if (idx_reg + CW'(1) == count_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_DEL_RD;
                    end
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    outcome_next = OUT_NOT_FOUND;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_FIND_RD;
                end
            end
            ST_DEL_RD:
            begin
                ram_raddr  = IW'(idx_reg + CW'(1));
                state_next = ST_DEL_WR;
            end
            ST_DEL_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                idx_next  = idx_reg + CW'(1);
                if (idx_reg + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DEL_RD;
                end
            end
            ST_LIST_RD:
            begin
                state_next = ST_LIST_OUT;
            end
            ST_LIST_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.outcome        = OUT_ENTRY;
                    rsp_next.entry_priority = ram_rdata.prio;
                    rsp_next.entry_tag      = ram_rdata.tag;
                    rsp_next.entry_status   = ram_rdata.status;
                    rsp_next.last           = (idx_reg + CW'(1) == count_reg);
                    if (idx_reg + CW'(1) == count_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_LIST_RD;
                    end
                end
            end
            ST_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.outcome        = outcome_reg;
                    rsp_next.entry_priority = '0;
                    rsp_next.entry_tag      = '0;
                    rsp_next.entry_status   = '0;
                    rsp_next.last           = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        outcome_reg <= outcome_next;
        rsp_reg     <= rsp_next;
    end

    `CHECK_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "entry count above capacity")

    `CHECK_SAME(a_list_in_range, state_reg == ST_LIST_OUT, idx_reg < count_reg, "list index past count")

    `CHECK_NEXT(a_full_drop, accept && req.req_type == REQ_INSERT && count_reg == CW'(CAPACITY), count_reg == $past(count_reg), "insert into full table changed count")

    `CHECK_SAME(a_idle_no_write, state_reg == ST_IDLE && !accept, !ram_we, "table written while idle")

endmodule

`default_nettype wire

// ----- sv/pstt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pstt_ram #(
    parameter int WIDTH = pstt_pkg::PSTT_ENTRY_W,
    parameter int DEPTH = pstt_pkg::PSTT_CAPACITY
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/pstt_cmp.sv -----
// Shared priority comparator: stored priority against the request key.
`timescale 1ns / 1ps
`default_nettype none

module pstt_cmp (
    input  wire logic signed [15:0] stored,
    input  wire logic signed [15:0] key,
    output pstt_pkg::cmp_t          res
);

    import pstt_pkg::*;

    always_comb
    begin
        res.eq = (stored == key);
        res.gt = (stored > key);
    end

endmodule

`default_nettype wire
